FILE: rtl/trfe_pkg.sv
// Package with the shared types, constants and tables of the target range block.
package trfe_pkg;

	localparam int XW  = 31;
	localparam int ZW  = 26;
	localparam int NW  = 47;
	localparam int YMW = 30;
	localparam int CORDIC_STEPS = 16;

	localparam logic [2:0] REG_LED_ON     = 3'd0;
	localparam logic [2:0] REG_MOUNT      = 3'd1;
	localparam logic [2:0] REG_HEIGHT     = 3'd2;
	localparam logic [2:0] REG_MIN_DIST   = 3'd3;
	localparam logic [2:0] REG_MAX_DIST   = 3'd4;

	localparam logic [1:0] DSEL_RANGE = 2'd0;
	localparam logic [1:0] DSEL_RSUM  = 2'd1;
	localparam logic [1:0] DSEL_ASUM  = 2'd2;

	localparam logic signed [16:0] QUARTER_TURN = 17'sd23040;
	localparam logic signed [16:0] HALF_TURN    = 17'sd46080;
	localparam logic [15:0] RANGE_MAX = 16'hFFFF;

	typedef struct packed {
		logic       load;
		logic       cordic;
		logic       mul;
		logic       classify;
		logic       div_load;
		logic [1:0] div_sel;
		logic       div_step;
		logic       take_rng;
		logic       win_upd;
		logic       sum_acc;
		logic       take_ravg;
		logic       take_aavg;
		logic       publish;
		logic [3:0] idx;
	} cmd_t;

	typedef struct packed {
		logic div_needed;
		logic sum_last;
	} sts_t;

	function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			4'd0:  r = 26'sd2949120;
			4'd1:  r = 26'sd1740967;
			4'd2:  r = 26'sd919879;
			4'd3:  r = 26'sd466945;
			4'd4:  r = 26'sd234379;
			4'd5:  r = 26'sd117304;
			4'd6:  r = 26'sd58666;
			4'd7:  r = 26'sd29335;
			4'd8:  r = 26'sd14668;
			4'd9:  r = 26'sd7334;
			4'd10: r = 26'sd3667;
			4'd11: r = 26'sd1833;
			4'd12: r = 26'sd917;
			4'd13: r = 26'sd458;
			4'd14: r = 26'sd229;
			4'd15: r = 26'sd115;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/trfe_ctrl.sv
// Controller state machine sequencing the range and averaging datapath.
module trfe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  trfe_pkg::sts_t sts,
	output trfe_pkg::cmd_t cmd
);
	import trfe_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CORD  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_CLS   = 4'd3;
	localparam logic [3:0] ST_DIVR  = 4'd4;
	localparam logic [3:0] ST_TAKER = 4'd5;
	localparam logic [3:0] ST_UPD   = 4'd6;
	localparam logic [3:0] ST_SUM   = 4'd7;
	localparam logic [3:0] ST_LDA   = 4'd8;
	localparam logic [3:0] ST_DIVA  = 4'd9;
	localparam logic [3:0] ST_TKA   = 4'd10;
	localparam logic [3:0] ST_DIVB  = 4'd11;
	localparam logic [3:0] ST_TKB   = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	logic [3:0] state_q, state_d;
	logic [3:0] idx_q, idx_d;
	logic       tvalid_q;
	logic       out_free;

	assign out_free = !tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = tvalid_q;

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.div_sel = DSEL_RANGE;
		state_d = state_q;
		idx_d = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					idx_d = '0;
					state_d = ST_CORD;
				end
			end
			ST_CORD: begin
				cmd.cordic = 1'b1;
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd15) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CLS;
			end
			ST_CLS: begin
				cmd.classify = 1'b1;
				cmd.div_load = 1'b1;
				cmd.div_sel = DSEL_RANGE;
				idx_d = '0;
				state_d = sts.div_needed ? ST_DIVR : ST_UPD;
			end
			ST_DIVR: begin
				cmd.div_step = 1'b1;
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd15) state_d = ST_TAKER;
			end
			ST_TAKER: begin
				cmd.take_rng = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.win_upd = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_acc = 1'b1;
				if (sts.sum_last) state_d = ST_LDA;
			end
			ST_LDA: begin
				cmd.div_load = 1'b1;
				cmd.div_sel = DSEL_RSUM;
				idx_d = '0;
				state_d = ST_DIVA;
			end
			ST_DIVA: begin
				cmd.div_step = 1'b1;
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd15) state_d = ST_TKA;
			end
			ST_TKA: begin
				cmd.take_ravg = 1'b1;
				cmd.div_load = 1'b1;
				cmd.div_sel = DSEL_ASUM;
				idx_d = '0;
				state_d = ST_DIVB;
			end
			ST_DIVB: begin
				cmd.div_step = 1'b1;
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd15) state_d = ST_TKB;
			end
			ST_TKB: begin
				cmd.take_aavg = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (cmd.publish) tvalid_q <= 1'b1;
			else if (m_tready) tvalid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/trfe_dp.sv
// Datapath: configuration registers, CORDIC, multiplier, shared divider and sample windows.
module trfe_dp #(
	parameter int WINDOW_DEPTH = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_wdata,
	input  logic [31:0]   s_tdata,
	input  logic          s_tuser,
	output logic [47:0]   m_tdata,
	output logic          m_tuser,
	input  trfe_pkg::cmd_t cmd,
	output trfe_pkg::sts_t sts
);
	import trfe_pkg::*;

	localparam int CW  = $clog2(WINDOW_DEPTH + 1);
	localparam int IW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int RSW = 16 + CW;
	localparam int ASW = 14 + CW;

	logic               led_q;
	logic signed [15:0] mount_q, height_q;
	logic [15:0]        min_q, max_q;

	logic               seen_q;
	logic signed [13:0] horiz_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [NW-1:0]      n_q;
	logic [15:0]        rng_q;
	logic               div_path_q;
	logic               valid_q;
	logic [NW-1:0]      rem_q;
	logic [YMW-1:0]     dsr_q;
	logic [15:0]        quo_q;
	logic [15:0]        ravg_q;
	logic signed [13:0] aavg_q;
	logic [15:0]        rwin_q [WINDOW_DEPTH];
	logic signed [13:0] awin_q [WINDOW_DEPTH];
	logic [CW-1:0]      fill_q;
	logic [IW-1:0]      sidx_q;
	logic [RSW-1:0]     rsum_q;
	logic signed [ASW-1:0] asum_q;
	logic [47:0]        out_data_q;
	logic               out_user_q;

	logic signed [16:0] a_sum, a_red;
	logic signed [XW-1:0] xs, ys;
	logic [NW-1:0]      nmag;
	logic [YMW-1:0]     ymag;
	logic [XW-1:0]      yneg;
	logic               y_zero, n_pos, neg_rng, sat;
	logic [NW-1:0]      trial;
	logic [3:0]         bit_pos;
	logic               valid_now;
	logic [ASW-1:0]     amag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q <= 1'b1;
			mount_q <= '0;
			height_q <= '0;
			min_q <= '0;
			max_q <= RANGE_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LED_ON:   led_q <= cfg_wdata[0];
				REG_MOUNT:    mount_q <= cfg_wdata;
				REG_HEIGHT:   height_q <= cfg_wdata;
				REG_MIN_DIST: min_q <= cfg_wdata;
				REG_MAX_DIST: max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		a_sum = {{3{s_tdata[27]}}, s_tdata[27:14]} + {mount_q[15], mount_q};
		if (a_sum > QUARTER_TURN) a_red = a_sum - HALF_TURN;
		else if (a_sum <= -QUARTER_TURN) a_red = a_sum + HALF_TURN;
		else a_red = a_sum;
	end

	assign xs = x_q >>> cmd.idx;
	assign ys = y_q >>> cmd.idx;

	assign nmag = n_q[NW-1] ? (NW'(0) - n_q) : n_q;
	assign yneg = XW'(0) - XW'(y_q);
	assign ymag = y_q[XW-1] ? yneg[YMW-1:0] : y_q[YMW-1:0];
	assign y_zero = (y_q == '0);
	assign n_pos = !n_q[NW-1] && (n_q != '0);
	assign neg_rng = (n_q != '0) && (n_q[NW-1] != y_q[XW-1]);
	assign sat = nmag >= {1'b0, ymag, 16'd0};
	assign sts.div_needed = !y_zero && !neg_rng && !sat;

	assign bit_pos = ~cmd.idx;
	assign trial = {{(NW-YMW){1'b0}}, dsr_q} << bit_pos;

	assign valid_now = led_q && seen_q && div_path_q && (rng_q >= min_q) && (rng_q <= max_q);
	assign sts.sum_last = (fill_q == '0) || (CW'(CW'(sidx_q) + CW'(1)) == fill_q);
	assign amag = asum_q[ASW-1] ? (ASW'(0) - ASW'(asum_q)) : ASW'(asum_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seen_q <= s_tuser;
			horiz_q <= s_tdata[13:0];
			x_q <= 31'sd268435456;
			y_q <= '0;
			z_q <= {a_red[16], a_red, 8'd0};
		end
		if (cmd.cordic) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_lut(cmd.idx);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_lut(cmd.idx);
			end
		end
		if (cmd.mul) begin
			n_q <= NW'(height_q * x_q);
		end
		if (cmd.classify) begin
			div_path_q <= sts.div_needed;
			if (y_zero) rng_q <= n_pos ? RANGE_MAX : 16'd0;
			else if (neg_rng) rng_q <= 16'd0;
			else rng_q <= RANGE_MAX;
		end
		if (cmd.div_load) begin
			quo_q <= '0;
			case (cmd.div_sel)
				DSEL_RANGE: begin
					rem_q <= nmag;
					dsr_q <= ymag;
				end
				DSEL_RSUM: begin
					rem_q <= NW'(rsum_q);
					dsr_q <= YMW'(fill_q);
				end
				DSEL_ASUM: begin
					rem_q <= NW'(amag);
					dsr_q <= YMW'(fill_q);
				end
				default: begin
					rem_q <= '0;
					dsr_q <= '0;
				end
			endcase
		end
		if (cmd.div_step && (rem_q >= trial)) begin
			rem_q <= rem_q - trial;
			quo_q[bit_pos] <= 1'b1;
		end
		if (cmd.take_rng) rng_q <= quo_q;
		if (cmd.win_upd) begin
			valid_q <= valid_now;
			sidx_q <= '0;
			rsum_q <= '0;
			asum_q <= '0;
		end
		if (cmd.sum_acc) begin
			rsum_q <= rsum_q + RSW'(rwin_q[sidx_q]);
			asum_q <= asum_q + {{CW{awin_q[sidx_q][13]}}, awin_q[sidx_q]};
			sidx_q <= sidx_q + IW'(1);
		end
		if (cmd.take_ravg) ravg_q <= (fill_q == '0) ? 16'd0 : quo_q;
		if (cmd.take_aavg) begin
			if (fill_q == '0) aavg_q <= '0;
			else if (asum_q[ASW-1]) aavg_q <= 14'd0 - quo_q[13:0];
			else aavg_q <= quo_q[13:0];
		end
		if (cmd.publish) begin
			out_data_q <= {2'b00, aavg_q, ravg_q, rng_q};
			out_user_q <= valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				rwin_q[i] <= '0;
				awin_q[i] <= '0;
			end
		end else if (cmd.win_upd) begin
			if (!valid_now) begin
				fill_q <= '0;
				for (int i = 0; i < WINDOW_DEPTH; i++) begin
					rwin_q[i] <= '0;
					awin_q[i] <= '0;
				end
			end else if (fill_q < CW'(WINDOW_DEPTH)) begin
				rwin_q[fill_q[IW-1:0]] <= rng_q;
				awin_q[fill_q[IW-1:0]] <= horiz_q;
				fill_q <= fill_q + CW'(1);
			end else begin
				for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
					rwin_q[i] <= rwin_q[i+1];
					awin_q[i] <= awin_q[i+1];
				end
				rwin_q[WINDOW_DEPTH-1] <= rng_q;
				awin_q[WINDOW_DEPTH-1] <= horiz_q;
			end
		end
	end

	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

endmodule

FILE: rtl/target_range_from_elevation_avg.sv
// Top level of the target range block with moving averages of range and horizontal angle.
//
// One camera sample enters as a transaction on the slave stream: tuser carries the
// target-seen flag and tdata the horizontal and vertical angles. For every sample exactly
// one result transaction leaves on the master stream: tuser is the valid flag and tdata
// holds the range, the windowed range average and the windowed angle average.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this. A sample passes
// from acceptance to result through 16 CORDIC iterations, one multiply, up to three passes
// of the shared restoring divider and one accumulation step per windowed entry for the
// sums, depending on whether the range division is needed and on the window fill.
// Only one sample is in work at a time; the next one is accepted in the cycle after the
// result is published at the earliest.
// s_tready is high while the controller waits for a sample, even when an earlier result
// still waits in the output register.
// If the receiver stalls, the finished result waits until the output register is free.
// Reset clears both windows and the fill count, sets the registers to their defaults and
// empties the output register.
module target_range_from_elevation_avg #(
	parameter int WINDOW_DEPTH = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // horizontal_angle[13:0], vertical_angle[27:14], zero pad
	input  logic        s_tuser,   // target_seen
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // range_now[15:0], range_average[31:16], angle_average[45:32]
	output logic        m_tuser    // valid_res
);
	import trfe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	trfe_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts(sts),
		.cmd(cmd)
	);

	trfe_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

FILE: rtl/trfe_checker.sv
// Port checker for the target range block, bound to the top level.
module trfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("A second transaction was taken while a sample was in work.");

	a_invalid_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[45:16] == 30'd0)
		else $error("An invalid sample returned non-zero averages.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("A stalled result transaction changed.");

endmodule

bind target_range_from_elevation_avg trfe_checker u_trfe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);
